// ----- rtl/ilst_pkg.sv -----
// Package: shared types, codes and widths for the indexed insert/delete list.
package ilst_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned MODE_W       = 2;
	localparam int unsigned POS_W        = 7;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned COUNT_W      = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [DATA_W-1:0]  removed_value;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

	// broadcast to every cell during the execute cycle
	typedef struct packed {
		logic                      ins;
		logic                      del;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

// ----- rtl/indexed_insert_delete_list_top.sv -----
// Module: top level of the indexed insert/delete list (row of shifting cells).
//
//  channel | signals          | handshake
//  --------+------------------+-------------------------------------------
//  request | start, req       | beat taken when start & !busy
//  result  | done, rsp        | one-cycle strobe, no back-pressure
//
// Each request is accepted, then executed: in the execute cycle every cell at or
// after the position shifts in parallel with its neighbor; the result strobes on the next
// cycle, when busy is already low again, so a new request can be taken then.
// Reset clears the length and the control flags; cell contents are left as is.
// The receiver cannot stall; results are never held.
module indexed_insert_delete_list_top #(
	parameter int unsigned CAPACITY = ilst_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ilst_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output ilst_pkg::rsp_t rsp
);

	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W  = (FILL_W > ilst_pkg::POS_W) ? FILL_W : ilst_pkg::POS_W;

	logic                  busy_q;
	logic                  done_q;
	ilst_pkg::req_t        req_q;
	ilst_pkg::rsp_t        rsp_q;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_d;

	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      fill_x;
	logic                  full;
	logic                  ins_ok;
	logic                  del_ok;
	ilst_pkg::status_t     status_d;
	ilst_pkg::cell_ctl_t   ctl;
	logic signed [ilst_pkg::DATA_W-1:0] removed;

	logic signed [ilst_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic signed [ilst_pkg::DATA_W-1:0] cell_tap  [CAPACITY];

	assign busy  = busy_q;
	assign done  = done_q;
	assign rsp   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			fill_q <= '0;
		end else begin
			done_q <= busy_q;
			if (busy_q) begin
				busy_q <= 1'b0;
				fill_q <= fill_d;
			end else if (start) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			req_q <= req;
		end
		if (busy_q) begin
			rsp_q.status        <= status_d;
			rsp_q.removed_value <= removed;
			rsp_q.count         <= ilst_pkg::COUNT_W'(fill_d);
		end
	end

	// request decode for the execute cycle
	always_comb begin
		pos_x    = CMP_W'(req_q.position);
		fill_x   = CMP_W'(fill_q);
		full     = (fill_q == FILL_W'(CAPACITY));
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		status_d = ilst_pkg::ST_DONE;
		fill_d   = fill_q;
		case (ilst_pkg::mode_t'(req_q.mode))
			ilst_pkg::MODE_INSERT: begin
				if (pos_x > fill_x) begin
					status_d = ilst_pkg::ST_BAD_INDEX;
				end else if (full) begin
					status_d = ilst_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
					fill_d = fill_q + FILL_W'(1);
				end
			end
			ilst_pkg::MODE_DELETE: begin
				if (pos_x >= fill_x) begin
					status_d = ilst_pkg::ST_BAD_INDEX;
				end else begin
					del_ok = 1'b1;
					fill_d = fill_q - FILL_W'(1);
				end
			end
			ilst_pkg::MODE_CLEAR: begin
				fill_d = '0;
			end
			default: begin
				fill_d = fill_q;
			end
		endcase
	end

	always_comb begin
		ctl.ins      = busy_q && ins_ok;
		ctl.del      = busy_q && del_ok;
		ctl.position = req_q.position;
		ctl.value    = req_q.value;
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < int'(CAPACITY); i++) begin
			removed = removed | cell_tap[i];
		end
		if (!del_ok) begin
			removed = '0;
		end
	end

	for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
		logic signed [ilst_pkg::DATA_W-1:0] left_w;
		logic signed [ilst_pkg::DATA_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = cell_data[g];
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == int'(CAPACITY) - 1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		ilst_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.left_in  (left_w),
			.right_in (right_w),
			.data     (cell_data[g]),
			.tap      (cell_tap[g])
		);
	end

endmodule

// ----- rtl/ilst_cell.sv -----
// Module: one list cell; holds one entry and shifts to/from its neighbors.
module ilst_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                                clk,
	input  ilst_pkg::cell_ctl_t                 ctl,
	input  logic signed [ilst_pkg::DATA_W-1:0]  left_in,
	input  logic signed [ilst_pkg::DATA_W-1:0]  right_in,
	output logic signed [ilst_pkg::DATA_W-1:0]  data,
	output logic signed [ilst_pkg::DATA_W-1:0]  tap
);

	logic signed [ilst_pkg::DATA_W-1:0] data_q;
	logic eq;
	logic gt;

	assign eq = (32'(ctl.position) == 32'(IDX));
	assign gt = (32'(IDX) > 32'(ctl.position));

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (eq) begin
				data_q <= ctl.value;
			end else if (gt) begin
				data_q <= left_in;
			end
		end else if (ctl.del && (eq || gt)) begin
			data_q <= right_in;
		end
	end

	assign data = data_q;
	// masked read for the delete result; ORed across the row
	assign tap  = eq ? data_q : '0;

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the indexed insert/delete list: queued driver, strobe monitor, in-order checks.
`timescale 1ns / 100ps

module tb_top;
	import ilst_pkg::*;

	localparam int unsigned LIST_CAP    = CAPACITY_DEF;
	localparam int unsigned RAND_OPS    = 1200;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned TAIL_CYCLES = 8;

	typedef enum int {PH_FILL, PH_GROW, PH_SHRINK, PH_NOISE} phase_t;

	typedef struct {
		req_t        r;
		int unsigned gap;     // idle cycles after this beat is taken
		bit          drain;   // hold this beat until every result is back
	} list_op_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// pending stimulus, expected results and the list image
	list_op_t    op_q[$];
	rsp_t        expected_rsp_q[$];
	logic signed [DATA_W-1:0] list_mem [LIST_CAP];
	int unsigned list_len;

	int unsigned gap_left;
	int unsigned err_cnt;
	int unsigned cycle_cnt;
	int unsigned gen_len;
	logic        taken;
	rsp_t        drv_exp;
	rsp_t        mon_exp;
	list_op_t    drv_op;

	indexed_insert_delete_list_top #(.CAPACITY(LIST_CAP)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// apply one request to the list image and return the result it should give
	function automatic rsp_t list_apply(input req_t r);
		rsp_t        o;
		int unsigned p;
		o = '0;
		o.status = ST_DONE;
		p = 32'(r.position);
		case (mode_t'(r.mode))
			MODE_INSERT: begin
				if (p > list_len) begin
					o.status = ST_BAD_INDEX;
				end else if (list_len >= LIST_CAP) begin
					o.status = ST_FULL;
				end else begin
					for (int unsigned k = list_len; k > p; k--) begin
						list_mem[k] = list_mem[k-1];
					end
					list_mem[p] = r.value;
					list_len++;
				end
			end
			MODE_DELETE: begin
				if (p >= list_len) begin
					o.status = ST_BAD_INDEX;
				end else begin
					o.removed_value = list_mem[p];
					for (int unsigned k = p; k + 1 < list_len; k++) begin
						list_mem[k] = list_mem[k+1];
					end
					list_len--;
				end
			end
			MODE_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		o.count = list_len[COUNT_W-1:0];
		return o;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) return 32'sh8000_0000;
		if (roll < 8) return 32'sh7FFF_FFFF;
		if (roll < 10) return -32'sd1;
		if (roll < 12) return 32'sd0;
		return $urandom;
	endfunction

	// queue one request, keeping the generator's idea of the list length in step
	task automatic push_op(input mode_t m, input int unsigned p,
			input logic signed [DATA_W-1:0] v, input int unsigned g, input bit dr);
		list_op_t op;
		op.r.mode     = m;
		op.r.position = p[POS_W-1:0];
		op.r.value    = v;
		op.gap        = g;
		op.drain      = dr;
		op_q.push_back(op);
		case (m)
			MODE_INSERT: if (p <= gen_len && gen_len < LIST_CAP) gen_len++;
			MODE_DELETE: if (p < gen_len) gen_len--;
			MODE_CLEAR:  gen_len = 0;
			default: ;
		endcase
	endtask

	// mostly legal positions, some just past the end, a few anywhere
	function automatic int unsigned pick_pos(input mode_t m);
		int unsigned roll;
		int unsigned top;
		roll = $urandom_range(0, 99);
		top  = (m == MODE_INSERT) ? gen_len : gen_len - 1;
		if (roll < 5 || (m == MODE_DELETE && gen_len == 0)) return $urandom_range(0, 127);
		if (roll < 15) return (m == MODE_INSERT) ? gen_len + 1 : gen_len;
		return $urandom_range(0, top);
	endfunction

	task automatic build_stimulus();
		int unsigned counted;
		int unsigned ph_len;
		int unsigned roll;
		bit          burst;
		phase_t      ph;
		mode_t       m;
		int unsigned p;

		gen_len = 0;
		// directed: empty-list errors, ends, middle, boundary indexes, nop, clear
		push_op(MODE_DELETE, 0,   32'sd5,         pick_gap(), 1'b0);
		push_op(MODE_INSERT, 1,   32'sd9,         pick_gap(), 1'b0);
		push_op(MODE_INSERT, 127, 32'sd9,         pick_gap(), 1'b0);
		push_op(MODE_NOP,    0,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_INSERT, 0,   32'sh8000_0000, pick_gap(), 1'b0);
		push_op(MODE_INSERT, 1,   32'sh7FFF_FFFF, pick_gap(), 1'b0);
		push_op(MODE_INSERT, 0,   -32'sd1,        pick_gap(), 1'b0);
		push_op(MODE_INSERT, 1,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_INSERT, 4,   32'sh5555_5555, pick_gap(), 1'b0);
		push_op(MODE_INSERT, 6,   32'sh1234_5678, pick_gap(), 1'b0);
		push_op(MODE_DELETE, 5,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_DELETE, 64,  32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_DELETE, 2,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_DELETE, 3,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_DELETE, 0,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_NOP,    127, 32'shDEAD_BEEF, pick_gap(), 1'b0);
		push_op(MODE_CLEAR,  127, 32'shFFFF_FFFF, pick_gap(), 1'b0);
		push_op(MODE_DELETE, 0,   32'sd0,         pick_gap(), 1'b0);
		push_op(MODE_INSERT, 0,   32'shAAAA_AAAA, pick_gap(), 1'b0);
		push_op(MODE_CLEAR,  0,   32'sd0,         pick_gap(), 1'b0);

		counted = 0;
		ph      = PH_FILL;
		while (counted < RAND_OPS) begin
			ph_len = $urandom_range(40, 160);
			burst  = ($urandom_range(0, 2) == 0);
			for (int unsigned i = 0; i < ph_len; i++) begin
				roll = $urandom_range(0, 99);
				case (ph)
					PH_FILL: begin
						m = MODE_INSERT;
						if (gen_len == LIST_CAP && roll < 30)
							p = $urandom_range(LIST_CAP + 1, 127);
						else
							p = $urandom_range(0, gen_len);
					end
					PH_GROW: begin
						m = (roll < 75) ? MODE_INSERT : (roll < 97) ? MODE_DELETE :
							(roll < 98) ? MODE_CLEAR : MODE_NOP;
						p = pick_pos(m);
					end
					PH_SHRINK: begin
						m = (roll < 75) ? MODE_DELETE : (roll < 97) ? MODE_INSERT :
							(roll < 98) ? MODE_CLEAR : MODE_NOP;
						p = pick_pos(m);
					end
					default: begin
						m = mode_t'($urandom_range(0, 3));
						p = $urandom_range(0, 127);
					end
				endcase
				push_op(m, p, pick_value(), burst ? 0 : pick_gap(),
					i == 0 && $urandom_range(0, 3) == 0);
				if (m != MODE_NOP) counted++;
			end
			roll = $urandom_range(0, 9);
			ph = (roll < 2) ? PH_FILL : (roll < 5) ? PH_GROW : (roll < 8) ? PH_SHRINK : PH_NOISE;
		end
	endtask

	initial begin
		build_stimulus();
		// the first random beat also waits for the directed results to drain
		op_q[20].drain = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (op_q.size() != 0 || start || expected_rsp_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// driver: a beat is taken at the edge where start is high and busy is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			req      <= '0;
			gap_left = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				drv_exp = list_apply(req);
				expected_rsp_q.push_back(drv_exp);
			end
			if (start && !taken) begin
				// beat still offered, hold it
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (op_q.size() != 0 &&
					!(op_q[0].drain && expected_rsp_q.size() != 0)) begin
				drv_op   = op_q.pop_front();
				req      <= drv_op.r;
				start    <= 1'b1;
				gap_left = drv_op.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: each strobe is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result strobe with no request outstanding");
				err_cnt++;
			end else begin
				mon_exp = expected_rsp_q.pop_front();
				if (rsp.status !== mon_exp.status) begin
					$error("status: expected %0d, got %0d", mon_exp.status, rsp.status);
					err_cnt++;
				end
				if (rsp.removed_value !== mon_exp.removed_value) begin
					$error("removed_value: expected %0d, got %0d",
						mon_exp.removed_value, rsp.removed_value);
					err_cnt++;
				end
				if (rsp.count !== mon_exp.count) begin
					$error("count: expected %0d, got %0d", mon_exp.count, rsp.count);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

endmodule

// ----- indexed_insert_delete_list_top.f -----
rtl/ilst_pkg.sv
rtl/ilst_cell.sv
rtl/indexed_insert_delete_list_top.sv
verif/tb_top.sv
